// ===== sv/ssi_pkg.sv =====
`default_nettype none

package ssi_pkg;

  // Default coordinate width: signed Q12.4.
  localparam int SSI_COORD_WIDTH = 16;

endpackage

`default_nettype wire

// ===== sv/segment_segment_intersect.sv =====
// Seven front stages, one divider stage per quotient bit and the output register, the
// first of which loads at the accepting edge. Throughput: one request per cycle while
// the output is not stalled; the divider sets the depth with one quotient bit per stage
// for each coordinate. The whole pipeline advances together and holds while a finished
// result is stalled.
// Reset (rst, synchronous) clears only the per-stage valid bits; data is not reset.
`default_nettype none

module segment_segment_intersect import ssi_pkg::*; #(
  parameter int COORD_WIDTH = SSI_COORD_WIDTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [COORD_WIDTH-1:0] seg1_start_x,
  input  wire logic signed [COORD_WIDTH-1:0] seg1_start_y,
  input  wire logic signed [COORD_WIDTH-1:0] seg1_end_x,
  input  wire logic signed [COORD_WIDTH-1:0] seg1_end_y,
  input  wire logic signed [COORD_WIDTH-1:0] seg2_start_x,
  input  wire logic signed [COORD_WIDTH-1:0] seg2_start_y,
  input  wire logic signed [COORD_WIDTH-1:0] seg2_end_x,
  input  wire logic signed [COORD_WIDTH-1:0] seg2_end_y,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               hit,
  output logic signed      [COORD_WIDTH-1:0] hit_x,
  output logic signed      [COORD_WIDTH-1:0] hit_y
);

  // Widths. Coordinate differences need one extra bit. Each cross product has a magnitude
  // below 2**(2W), and den, sn and tn below 2**(2W+1). Once den is made positive, tn lies
  // in [0, den], so the scaled numerator tn*|s1| is below 2**(3W+1).
  localparam int W     = COORD_WIDTH;
  localparam int DIFW  = W + 1;
  localparam int PW    = 2 * W + 1;
  localparam int SW    = 2 * W + 2;
  localparam int DU    = 2 * W + 1;
  localparam int LO    = W / 2;
  localparam int HI    = W - LO;
  localparam int MW    = DU + W;
  localparam int NW    = MW + 1;
  localparam int DDW   = DU + 1;
  localparam int FRONT = 7;
  localparam int NS    = FRONT + W + 1;
  localparam int SIDEX = W + 2;
  localparam int SIDEY = W + 1;

  // One valid bit per stage; a single enable moves every stage at once.
  logic [NS-1:0] vld;
  logic          adv;

  assign adv       = !vld[NS-1] || !out_stall;
  assign in_stall  = !adv;
  assign out_valid = vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NS-2:0], in_valid};
    end
  end

  // Stage 1: segment directions and the offset between the two start points.
  logic signed [DIFW-1:0] s1x1, s1y1, s2x1, s2y1, dx1, dy1;
  logic signed [W-1:0]    p0x1, p0y1;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1x1 <= DIFW'(seg1_end_x) - DIFW'(seg1_start_x);
      s1y1 <= DIFW'(seg1_end_y) - DIFW'(seg1_start_y);
      s2x1 <= DIFW'(seg2_end_x) - DIFW'(seg2_start_x);
      s2y1 <= DIFW'(seg2_end_y) - DIFW'(seg2_start_y);
      dx1  <= DIFW'(seg1_start_x) - DIFW'(seg2_start_x);
      dy1  <= DIFW'(seg1_start_y) - DIFW'(seg2_start_y);
      p0x1 <= seg1_start_x;
      p0y1 <= seg1_start_y;
    end
  end

  // Stage 2: the six cross-product terms, each its own multiplier.
  logic signed [PW-1:0]   ma2, mb2, mc2, md2, me2, mf2;
  logic signed [DIFW-1:0] s1x2, s1y2;
  logic signed [W-1:0]    p0x2, p0y2;

  always_ff @(posedge clk) begin
    if (adv) begin
      ma2  <= PW'(s1x1) * PW'(s2y1);
      mb2  <= PW'(s2x1) * PW'(s1y1);
      mc2  <= PW'(s1x1) * PW'(dy1);
      md2  <= PW'(s1y1) * PW'(dx1);
      me2  <= PW'(s2x1) * PW'(dy1);
      mf2  <= PW'(s2y1) * PW'(dx1);
      s1x2 <= s1x1;
      s1y2 <= s1y1;
      p0x2 <= p0x1;
      p0y2 <= p0y1;
    end
  end

  // Stage 3: the shared denominator and the two parameter numerators.
  logic signed [SW-1:0]   den3, sn3, tn3;
  logic signed [DIFW-1:0] s1x3, s1y3;
  logic signed [W-1:0]    p0x3, p0y3;

  always_ff @(posedge clk) begin
    if (adv) begin
      den3 <= SW'(ma2) - SW'(mb2);
      sn3  <= SW'(mc2) - SW'(md2);
      tn3  <= SW'(me2) - SW'(mf2);
      s1x3 <= s1x2;
      s1y3 <= s1y2;
      p0x3 <= p0x2;
      p0y3 <= p0y2;
    end
  end

  // Stage 4: flip all three signs when the denominator is negative so that the
  // range test becomes 0 <= sn <= den and 0 <= tn <= den. The direction of segment
  // one is split into a sign and a magnitude for the point computation.
  logic signed [SW-1:0] den4, sn4, tn4;
  logic                 dz4;
  logic                 negx4, negy4;
  logic [W-1:0]         smagx4, smagy4;
  logic signed [W-1:0]  p0x4, p0y4;

  always_ff @(posedge clk) begin
    if (adv) begin
      den4   <= den3[SW-1] ? -den3 : den3;
      sn4    <= den3[SW-1] ? -sn3 : sn3;
      tn4    <= den3[SW-1] ? -tn3 : tn3;
      dz4    <= (den3 == '0);
      negx4  <= s1x3[DIFW-1];
      negy4  <= s1y3[DIFW-1];
      smagx4 <= W'(s1x3[DIFW-1] ? -s1x3 : s1x3);
      smagy4 <= W'(s1y3[DIFW-1] ? -s1y3 : s1y3);
      p0x4   <= p0x3;
      p0y4   <= p0y3;
    end
  end

  // Stage 5: the hit decision, and tn times each magnitude as two half-width partial
  // products. A zero denominator never hits, which matches parallel segments.
  logic              hit5;
  logic [DU-1:0]     den5;
  logic [DU+LO-1:0]  plox5, ploy5;
  logic [DU+HI-1:0]  phix5, phiy5;
  logic              negx5, negy5;
  logic signed [W-1:0] p0x5, p0y5;
  logic [DU-1:0]     tnu4;

  assign tnu4 = tn4[DU-1:0];

  always_ff @(posedge clk) begin
    if (adv) begin
      hit5  <= !dz4 && !sn4[SW-1] && !tn4[SW-1] && (den4 >= sn4) && (den4 >= tn4);
      den5  <= den4[DU-1:0];
      plox5 <= (DU+LO)'(tnu4) * (DU+LO)'(smagx4[LO-1:0]);
      ploy5 <= (DU+LO)'(tnu4) * (DU+LO)'(smagy4[LO-1:0]);
      phix5 <= (DU+HI)'(tnu4) * (DU+HI)'(smagx4[W-1:LO]);
      phiy5 <= (DU+HI)'(tnu4) * (DU+HI)'(smagy4[W-1:LO]);
      negx5 <= negx4;
      negy5 <= negy4;
      p0x5  <= p0x4;
      p0y5  <= p0y4;
    end
  end

  // Stage 6: combine the partial products.
  logic              hit6;
  logic [DU-1:0]     den6;
  logic [MW-1:0]     magx6, magy6;
  logic              negx6, negy6;
  logic signed [W-1:0] p0x6, p0y6;

  always_ff @(posedge clk) begin
    if (adv) begin
      hit6  <= hit5;
      den6  <= den5;
      magx6 <= MW'(plox5) + (MW'(phix5) << LO);
      magy6 <= MW'(ploy5) + (MW'(phiy5) << LO);
      negx6 <= negx5;
      negy6 <= negy5;
      p0x6  <= p0x5;
      p0y6  <= p0y5;
    end
  end

  // Stage 7: rounding to nearest with ties up is floor((2*mag + den) / (2*den)).
  logic              hit7;
  logic [NW-1:0]     numx7, numy7;
  logic [DDW-1:0]    dvs7;
  logic              negx7, negy7;
  logic signed [W-1:0] p0x7, p0y7;

  always_ff @(posedge clk) begin
    if (adv) begin
      hit7  <= hit6;
      numx7 <= (NW'(magx6) << 1) + NW'(den6);
      numy7 <= (NW'(magy6) << 1) + NW'(den6);
      dvs7  <= {den6, 1'b0};
      negx7 <= negx6;
      negy7 <= negy6;
      p0x7  <= p0x6;
      p0y7  <= p0y6;
    end
  end

  // Divider lanes: the quotient never exceeds the direction magnitude, so W bits suffice.
  // The hit flag, the sign of the direction and the start point ride in the sideband.
  logic [W-1:0]     qx, qy;
  logic [SIDEX-1:0] sidex;
  logic [SIDEY-1:0] sidey;
  logic             hit_d, negx_d, negy_d;
  logic [W-1:0]     p0x_d, p0y_d;

  ssi_div #(
    .QUOT_WIDTH (W),
    .DIV_WIDTH  (DDW),
    .SIDE_WIDTH (SIDEX)
  ) u_div_x (
    .clk      (clk),
    .en       (adv),
    .num      (numx7),
    .dvs      (dvs7),
    .side_in  ({hit7, negx7, p0x7}),
    .quot     (qx),
    .side_out (sidex)
  );

  ssi_div #(
    .QUOT_WIDTH (W),
    .DIV_WIDTH  (DDW),
    .SIDE_WIDTH (SIDEY)
  ) u_div_y (
    .clk      (clk),
    .en       (adv),
    .num      (numy7),
    .dvs      (dvs7),
    .side_in  ({negy7, p0y7}),
    .quot     (qy),
    .side_out (sidey)
  );

  assign {hit_d, negx_d, p0x_d} = sidex;
  assign {negy_d, p0y_d}        = sidey;

  // Output stage: apply the sign of the direction and add the start point. The point lies
  // on segment one, so the sum wraps back into range with no saturation needed.
  logic [W-1:0] hit_x_next, hit_y_next;

  always_comb begin
    hit_x_next = '0;
    hit_y_next = '0;
    if (hit_d) begin
      hit_x_next = p0x_d + (negx_d ? (~qx + W'(1)) : qx);
      hit_y_next = p0y_d + (negy_d ? (~qy + W'(1)) : qy);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hit   <= hit_d;
      hit_x <= $signed(hit_x_next);
      hit_y <= $signed(hit_y_next);
    end
  end

  // A result without a hit carries a zero point.
  a_miss_is_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> (hit_x == '0) && (hit_y == '0))
    else $error("point is nonzero on a result without a hit");

  // While the pipeline is held, no stage gains or loses a request.
  a_hold_keeps_stages: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(vld))
    else $error("stage valid bits changed while the pipeline was held");

  // An accepted request always enters the first stage.
  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> vld[0])
    else $error("accepted request did not reach the first stage");

endmodule

`default_nettype wire

// ===== sv/ssi_div.sv =====
`default_nettype none

// Pipelined restoring divider, one quotient bit per stage, with a sideband that travels
// alongside each request. The dividend must be below the divisor times 2**QUOT_WIDTH.
module ssi_div import ssi_pkg::*; #(
  parameter int QUOT_WIDTH = SSI_COORD_WIDTH,
  parameter int DIV_WIDTH  = 2 * SSI_COORD_WIDTH + 2,
  parameter int SIDE_WIDTH = 1
) (
  input  wire logic                             clk,
  input  wire logic                             en,
  input  wire logic [QUOT_WIDTH+DIV_WIDTH-1:0]  num,
  input  wire logic [DIV_WIDTH-1:0]             dvs,
  input  wire logic [SIDE_WIDTH-1:0]            side_in,
  output logic      [QUOT_WIDTH-1:0]            quot,
  output logic      [SIDE_WIDTH-1:0]            side_out
);

  localparam int NUM_WIDTH = QUOT_WIDTH + DIV_WIDTH;

  logic [DIV_WIDTH-1:0]  rem    [QUOT_WIDTH];
  logic [DIV_WIDTH-1:0]  dvs_r  [QUOT_WIDTH];
  logic [QUOT_WIDTH-1:0] low    [QUOT_WIDTH];
  logic [QUOT_WIDTH-1:0] quot_r [QUOT_WIDTH];
  logic [SIDE_WIDTH-1:0] side_r [QUOT_WIDTH];

  for (genvar k = 0; k < QUOT_WIDTH; k++) begin : g_stage
    logic [DIV_WIDTH-1:0]  rem_prev;
    logic [DIV_WIDTH-1:0]  dvs_prev;
    logic [QUOT_WIDTH-1:0] low_prev;
    logic [QUOT_WIDTH-1:0] quot_prev;
    logic [SIDE_WIDTH-1:0] side_prev;
    logic [DIV_WIDTH:0]    trial;
    logic [DIV_WIDTH:0]    diff;
    logic                  ge;

    if (k == 0) begin : g_first
      // The upper dividend bits are already below the divisor.
      assign rem_prev  = num[NUM_WIDTH-1 -: DIV_WIDTH];
      assign low_prev  = num[QUOT_WIDTH-1:0];
      assign dvs_prev  = dvs;
      assign quot_prev = '0;
      assign side_prev = side_in;
    end else begin : g_rest
      assign rem_prev  = rem[k-1];
      assign low_prev  = low[k-1];
      assign dvs_prev  = dvs_r[k-1];
      assign quot_prev = quot_r[k-1];
      assign side_prev = side_r[k-1];
    end

    assign trial = {rem_prev, low_prev[QUOT_WIDTH-1]};
    assign diff  = trial - {1'b0, dvs_prev};
    assign ge    = (trial >= {1'b0, dvs_prev});

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k]    <= ge ? diff[DIV_WIDTH-1:0] : trial[DIV_WIDTH-1:0];
        low[k]    <= low_prev << 1;
        dvs_r[k]  <= dvs_prev;
        quot_r[k] <= {quot_prev[QUOT_WIDTH-2:0], ge};
        side_r[k] <= side_prev;
      end
    end
  end

  assign quot     = quot_r[QUOT_WIDTH-1];
  assign side_out = side_r[QUOT_WIDTH-1];

endmodule

`default_nettype wire
